FILE: hdl/apm_pkg.sv
// Shared types and constants for the audio peak level meter.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package apm_pkg;

	// Frame counter width
	localparam int COUNT_BITS = 16;
	localparam int PERIOD_BITS = 16;
	localparam int CMP_BITS = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

	localparam int MAG_BITS = 32;
	localparam int DUR_BITS = 20;
	localparam int SQ_BITS = 32;
	localparam int PROD_BITS = SQ_BITS + DUR_BITS;
	localparam int ENERGY_BITS = 64;
	localparam int TIME_BITS = 48;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_SAMPLE    = 2'd0,
		OP_CLR_LEVEL = 2'd1,
		OP_CLR_ALL   = 2'd2,
		OP_NONE      = 2'd3
	} apm_op_t;

	localparam logic [1:0] FMT_INT8  = 2'd0;
	localparam logic [1:0] FMT_INT16 = 2'd1;
	localparam logic [1:0] FMT_INT32 = 2'd2;

	localparam logic [1:0] FMT_RESET = FMT_INT16;
	localparam logic [15:0] PERIOD_RESET = 16'd10;

	// Register indexes (word address bit 2)
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	// Work handed from front to back
	typedef struct packed {
		logic                  clr_all;
		logic [MAG_BITS-1:0]   level;
		logic [MAG_BITS-1:0]   peak;
		logic [DUR_BITS-1:0]   dur;
	} apm_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SQ   = 4'b0010,
		ST_PROD = 4'b0100,
		ST_ACC  = 4'b1000
	} apm_back_st_t;

endpackage

FILE: hdl/apm_front.sv
// Front part: accepts requests, folds sample magnitudes into the peak and
// runs the frame counter. Depends on apm_pkg.
module apm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    width_sel,
	input  logic [15:0]                   update_period,
	input  logic                          accept,
	input  logic [1:0]                    op,
	input  logic [31:0]                   sample,
	input  logic                          frame_end,
	input  logic [apm_pkg::DUR_BITS-1:0]  dur,
	output logic                          push,
	output apm_pkg::apm_entry_t           push_entry
);

	logic [31:0]                     peak_q;
	logic [31:0]                     level_q;
	logic [apm_pkg::COUNT_BITS-1:0]  counter_q;

	logic [31:0] mag;
	logic [7:0]  mag8;
	logic [15:0] mag16;
	logic [31:0] peak_new;
	logic        match;

	always_comb begin
		mag8  = sample[7] ? (8'd0 - sample[7:0]) : sample[7:0];
		mag16 = sample[15] ? (16'd0 - sample[15:0]) : sample[15:0];
		case (width_sel)
			apm_pkg::FMT_INT8:  mag = {mag8, 24'd0};
			apm_pkg::FMT_INT16: mag = {mag16, 16'd0};
			default:            mag = sample[31] ? (32'd0 - sample) : sample;
		endcase
		peak_new = (mag > peak_q) ? mag : peak_q;
		match = (apm_pkg::CMP_BITS'(counter_q) == apm_pkg::CMP_BITS'(update_period));
	end

	always_comb begin
		push = 1'b0;
		push_entry.clr_all = 1'b0;
		push_entry.level   = match ? peak_new : level_q;
		push_entry.peak    = match ? {2'b00, peak_new[31:2]} : peak_new;
		push_entry.dur     = dur;
		case (apm_pkg::apm_op_t'(op))
			apm_pkg::OP_SAMPLE: push = accept & frame_end;
			apm_pkg::OP_CLR_ALL: begin
				push = accept;
				push_entry.clr_all = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q    <= '0;
			level_q   <= '0;
			counter_q <= '0;
		end else if (accept) begin
			case (apm_pkg::apm_op_t'(op))
				apm_pkg::OP_SAMPLE: begin
					if (!frame_end) begin
						peak_q <= peak_new;
					end else if (match) begin
						level_q   <= peak_new;
						peak_q    <= {2'b00, peak_new[31:2]};
						counter_q <= '0;
					end else begin
						peak_q    <= peak_new;
						counter_q <= counter_q + apm_pkg::COUNT_BITS'(1);
					end
				end
				apm_pkg::OP_CLR_LEVEL, apm_pkg::OP_CLR_ALL: begin
					peak_q    <= '0;
					level_q   <= '0;
					counter_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: hdl/apm_fifo.sv
// Short queue of frame-end and clear-all work between front and back.
// Depends on apm_pkg.
module apm_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  apm_pkg::apm_entry_t  push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 avail,
	output apm_pkg::apm_entry_t  head
);

	apm_pkg::apm_entry_t                mem_q [apm_pkg::FIFO_DEPTH];
	logic [apm_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_q;
	logic [apm_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_q;
	logic [apm_pkg::FIFO_CNT_BITS-1:0]  count_q;

	assign full  = (count_q == apm_pkg::FIFO_CNT_BITS'(apm_pkg::FIFO_DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + apm_pkg::FIFO_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + apm_pkg::FIFO_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + apm_pkg::FIFO_CNT_BITS'(1);
			end else if (!push && pop) begin
				count_q <= count_q - apm_pkg::FIFO_CNT_BITS'(1);
			end
		end
	end

endmodule

FILE: hdl/apm_back.sv
// Back part: squares the level, scales by frame duration, keeps the
// saturating totals and holds the result register. Depends on apm_pkg.
module apm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	input  apm_pkg::apm_entry_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [175:0]         out_data
);

	apm_pkg::apm_back_st_t               state_q;
	logic [31:0]                         level_q;
	logic [31:0]                         peak_q;
	logic [apm_pkg::DUR_BITS-1:0]        dur_q;
	logic [apm_pkg::SQ_BITS-1:0]         sq_q;
	logic [apm_pkg::PROD_BITS-1:0]       prod_q;
	logic [apm_pkg::ENERGY_BITS-1:0]     energy_q;
	logic [apm_pkg::TIME_BITS-1:0]       time_q;
	logic                                out_valid_q;
	logic [175:0]                        out_data_q;

	logic [63:0]                         sq_full;
	logic [apm_pkg::ENERGY_BITS:0]       energy_sum;
	logic [apm_pkg::TIME_BITS:0]         time_sum;
	logic [apm_pkg::ENERGY_BITS-1:0]     energy_new;
	logic [apm_pkg::TIME_BITS-1:0]       time_new;
	logic                                out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == apm_pkg::ST_IDLE) && avail;

	always_comb begin
		sq_full    = 64'(level_q) * 64'(level_q);
		energy_sum = {1'b0, energy_q} + (apm_pkg::ENERGY_BITS + 1)'(prod_q);
		time_sum   = {1'b0, time_q} + (apm_pkg::TIME_BITS + 1)'(dur_q);
		energy_new = energy_sum[apm_pkg::ENERGY_BITS] ? '1 :
			energy_sum[apm_pkg::ENERGY_BITS-1:0];
		time_new   = time_sum[apm_pkg::TIME_BITS] ? '1 : time_sum[apm_pkg::TIME_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			apm_pkg::ST_IDLE: begin
				level_q <= head.level;
				peak_q  <= head.peak;
				dur_q   <= head.dur;
			end
			apm_pkg::ST_SQ:   sq_q   <= sq_full[62:31];
			apm_pkg::ST_PROD: prod_q <= apm_pkg::PROD_BITS'(sq_q) * apm_pkg::PROD_BITS'(dur_q);
			apm_pkg::ST_ACC: begin
				if (out_free) begin
					out_data_q <= {time_new, energy_new, peak_q, level_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apm_pkg::ST_IDLE;
			energy_q    <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// New result loads the register; otherwise a taken result empties it
			if ((state_q == apm_pkg::ST_ACC) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				apm_pkg::ST_IDLE: begin
					if (avail) begin
						if (head.clr_all) begin
							energy_q <= '0;
							time_q   <= '0;
						end else begin
							state_q <= apm_pkg::ST_SQ;
						end
					end
				end
				apm_pkg::ST_SQ:   state_q <= apm_pkg::ST_PROD;
				apm_pkg::ST_PROD: state_q <= apm_pkg::ST_ACC;
				apm_pkg::ST_ACC: begin
					if (out_free) begin
						energy_q <= energy_new;
						time_q   <= time_new;
						state_q  <= apm_pkg::ST_IDLE;
					end
				end
				default: state_q <= apm_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/audio_peak_level_meter_top.sv
// Top level of the audio peak level meter: register port, front, queue, back.
// Depends on apm_pkg, apm_front, apm_fifo and apm_back.
//
// The meter takes one request per cycle on the slave stream while the queue
// is not full. tuser carries the op (sample, clear level/peak/counter, clear
// all), tlast marks the last sample of a frame, tdata carries the sample and
// the frame duration. Each sample is turned into a Q1.31 magnitude (full
// scale 2^31) and folded into a peak in the same cycle, so sample requests
// run at one per cycle while the queue is not full. A frame end or a clear-all
// request is put on a four-deep queue; the back end takes each frame end
// through queue pop, square of the level, scale by duration and saturating
// accumulate, because the square and the duration product each take a
// registered multiplier stage, and handles a clear-all in the pop state alone.
// The slave side stalls only while the queue is full: five back-to-back frame
// ends are absorbed (four queued, one in the back end) and a sixth waits, and a
// result held off on the master side backs work up into the queue in the same
// way. The result is held in an output register, so the back end can carry the
// next frame end up to its accumulate step while a result waits.
// Registers: 0x0 sample width (0 int8, 1 int16, 2/3 int32), 0x4
// update_period; write only while the meter is idle.
module audio_peak_level_meter_top (
	input  logic         clk,
	input  logic         arst_n,
	// APB register port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [55:0]  s_tdata,  // [31:0] sample, [51:32] frame_duration_us, rest zero
	input  logic         s_tlast,  // frame_end
	input  logic [1:0]   s_tuser,  // [1:0] op
	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata   // [31:0] level, [63:32] peak, [127:64] energy_total,
	                               // [175:128] total_time_us
);

	logic [1:0]  width_sel_q;
	logic [15:0] update_period_q;

	logic                 accept;
	logic                 push;
	apm_pkg::apm_entry_t  push_entry;
	logic                 full;
	logic                 pop;
	logic                 avail;
	apm_pkg::apm_entry_t  head;
	logic                 wr_en;

	// Register port: always ready, low address bits ignored
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign prdata = (paddr[2] == apm_pkg::REG_PERIOD) ? {16'd0, update_period_q} :
		{30'd0, width_sel_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_sel_q     <= apm_pkg::FMT_RESET;
			update_period_q <= apm_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			if (paddr[2] == apm_pkg::REG_FORMAT) begin
				width_sel_q <= pwdata[1:0];
			end else begin
				update_period_q <= pwdata[15:0];
			end
		end
	end

	// Stall every request while the queue is full, keeping order simple
	assign s_tready = !full;
	assign accept   = s_tvalid & s_tready;

	apm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.width_sel     (width_sel_q),
		.update_period (update_period_q),
		.accept        (accept),
		.op            (s_tuser),
		.sample        (s_tdata[31:0]),
		.frame_end     (s_tlast),
		.dur           (s_tdata[51:32]),
		.push          (push),
		.push_entry    (push_entry)
	);

	apm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.avail      (avail),
		.head       (head)
	);

	apm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (avail),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

FILE: dv/tb_audio_peak_level_meter_top.sv
// Self-checking testbench for audio_peak_level_meter_top: stream requests in, frame results out.
// A built-in predictor of the meter supplies the expected results. Depends on apm_pkg and the RTL.
module tb_audio_peak_level_meter_top;
	import apm_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 6;
	// Drain margin for the back end working behind a four-deep queue, plus the output register
	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	// Longest legal quiet spell is the output hold; random idling never gets near this
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_REQS  = 760;
	localparam int FULL_FRAMES  = 32;
	localparam int MAX_PRINTS   = 40;

	localparam logic [1:0]  FMT_UNUSED = 2'd3;
	localparam logic [19:0] DUR_MAX    = 20'hFFFFF;

	typedef struct {
		logic [31:0] level;
		logic [31:0] peak;
		logic [63:0] energy;
		logic [47:0] time_us;
	} meter_result_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [55:0]  s_tdata  = '0;   // [31:0] sample, [51:32] frame_duration_us, rest zero
	logic         s_tlast  = 1'b0; // frame_end
	logic [1:0]   s_tuser  = '0;   // [1:0] op
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [175:0] m_tdata;         // [31:0] level, [63:32] peak, [127:64] energy_total,
	                               // [175:128] total_time_us

	audio_peak_level_meter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Meter state as the predictor sees it; starts at the reset values
	logic [1:0]            cfg_fmt    = FMT_RESET;
	logic [15:0]           cfg_period = PERIOD_RESET;
	logic [31:0]           peak_hold  = '0;
	logic [31:0]           shown_lvl  = '0;
	logic [COUNT_BITS-1:0] frame_cnt  = '0;
	logic [63:0]           energy_acc = '0;
	logic [47:0]           time_acc   = '0;

	meter_result_t frame_results_due[$];

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int mismatch_count = 0;
	int reqs_accepted  = 0;
	int results_seen   = 0;
	int quiet_cycles   = 0;
	// Output hold: the test bumps hold_reqs, the receiver process does the counting
	int hold_reqs      = 0;
	int holds_started  = 0;
	int hold_left      = 0;

	task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH %s: got %h, expected %h (after %0d results)",
				what, got, want, results_seen);
	endtask

	// Q1.31 magnitude of a sample at the given width; the most negative code maps to 2^31
	function automatic logic [31:0] sample_magnitude(logic [1:0] fmt, logic [31:0] raw);
		logic [31:0] v;
		case (fmt)
			FMT_INT8: begin
				v = {24'd0, raw[7:0]};
				if (raw[7])
					v = 32'h100 - v;
				return v << 24;
			end
			FMT_INT16: begin
				v = {16'd0, raw[15:0]};
				if (raw[15])
					v = 32'h10000 - v;
				return v << 16;
			end
			default: begin
				// int32 and the unused code
				return raw[31] ? 32'd0 - raw : raw;
			end
		endcase
	endfunction

	// Advance the predicted meter by one accepted request; a frame end queues its result
	task automatic predict_request(apm_op_t op, logic [31:0] smp, logic last, logic [19:0] dur);
		logic [31:0]   mag;
		logic [63:0]   lvl_wide;
		logic [63:0]   lvl_sq;
		logic [63:0]   frame_energy;
		logic [64:0]   energy_sum;
		logic [48:0]   time_sum;
		meter_result_t res;
		case (op)
			OP_CLR_LEVEL, OP_CLR_ALL: begin
				peak_hold = '0;
				shown_lvl = '0;
				frame_cnt = '0;
				if (op == OP_CLR_ALL) begin
					energy_acc = '0;
					time_acc   = '0;
				end
			end
			OP_SAMPLE: begin
				mag = sample_magnitude(cfg_fmt, smp);
				if (mag > peak_hold)
					peak_hold = mag;
				if (last) begin
					// Publish once the counter has reached the period, then decay by 4
					if (frame_cnt == cfg_period) begin
						shown_lvl = peak_hold;
						frame_cnt = '0;
						peak_hold = peak_hold >> 2;
					end else begin
						frame_cnt = frame_cnt + 1'b1;
					end
					lvl_wide     = {32'd0, shown_lvl};
					lvl_sq       = (lvl_wide * lvl_wide) >> 31;
					frame_energy = lvl_sq * {44'd0, dur};
					energy_sum   = {1'b0, energy_acc} + {1'b0, frame_energy};
					energy_acc   = energy_sum[64] ? '1 : energy_sum[63:0];
					time_sum     = {1'b0, time_acc} + {29'd0, dur};
					time_acc     = time_sum[48] ? '1 : time_sum[47:0];
					res.level   = shown_lvl;
					res.peak    = peak_hold;
					res.energy  = energy_acc;
					res.time_us = time_acc;
					frame_results_due.push_back(res);
				end
			end
			default: ; // OP_NONE leaves everything alone
		endcase
	endtask

	// One APB transfer, setup then access; ends with psel dropped so transfers can follow
	task automatic apb_transfer(logic wr, logic idx, logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(logic idx, logic [31:0] want);
		logic [31:0] got;
		apb_transfer(1'b0, idx, '0, got);
		if (got !== want)
			note_mismatch(idx == REG_FORMAT ? "sample width readback" : "update_period readback",
				{32'd0, got}, {32'd0, want});
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Drop the request valid, let every due result arrive, then give the pipe time to settle
	task automatic wait_for_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Registers are only touched with the meter idle
	task automatic set_config(logic [1:0] fmt, logic [15:0] period);
		logic [31:0] unused_rd;
		wait_for_quiet();
		apb_transfer(1'b1, REG_FORMAT, {30'd0, fmt}, unused_rd);
		check_reg(REG_FORMAT, {30'd0, fmt});
		apb_transfer(1'b1, REG_PERIOD, {16'd0, period}, unused_rd);
		check_reg(REG_PERIOD, {16'd0, period});
		cfg_fmt    = fmt;
		cfg_period = period;
	endtask

	// Offer one request (after an optional random gap) and hold it until it is taken
	task automatic send_request(apm_op_t op, logic [31:0] smp, logic last, logic [19:0] dur);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= last;
		s_tdata  <= {4'd0, dur, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_request(op, smp, last, dur);
		reqs_accepted++;
	endtask

	function automatic logic [31:0] pick_sample();
		logic [31:0] v;
		case ($urandom_range(4))
			0: begin
				// quiet signal of either sign
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1))
					v = 32'd0 - v;
			end
			1: begin
				// edges of each width, with junk in the unused upper bits
				case ($urandom_range(5))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = {16'($urandom), 16'h8000};
					3:       v = {24'($urandom), 8'h80};
					4:       v = {16'($urandom), 16'h7FFF};
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [19:0] pick_duration();
		case ($urandom_range(3))
			0:       return 20'($urandom_range(0, 100));
			1:       return DUR_MAX;
			2:       return '0;
			default: return 20'($urandom);
		endcase
	endfunction

	// One frame of random samples, with a sprinkling of clears, ignored ops and missing frame ends
	task automatic send_random_frame(output int counted);
		int   len;
		int   roll;
		logic broken;
		counted = 0;
		len    = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 10);
		broken = ($urandom_range(19) == 0);
		for (int i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				send_request(OP_CLR_LEVEL, $urandom, 1'($urandom), pick_duration());
				counted++;
			end else if (roll < 5) begin
				send_request(OP_CLR_ALL, $urandom, 1'($urandom), pick_duration());
				counted++;
			end else if (roll < 8) begin
				send_request(OP_NONE, $urandom, 1'($urandom), pick_duration());
			end else begin
				send_request(OP_SAMPLE, pick_sample(), (i == len - 1) && !broken,
					pick_duration());
				counted++;
			end
		end
	endtask

	// Reset values of both registers, and int16 handling before anything is written
	task automatic test_reset_defaults();
		check_reg(REG_FORMAT, {30'd0, FMT_RESET});
		check_reg(REG_PERIOD, {16'd0, PERIOD_RESET});
		send_request(OP_SAMPLE, 32'hABCD_7FFF, 1'b0, 20'h12345);
		send_request(OP_SAMPLE, 32'h0000_8000, 1'b1, 20'd0);
		send_request(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 20'd1);
	endtask

	// int8 with period 0: publish on every frame, full scale from -128, upper bits ignored
	task automatic test_int8_format();
		set_config(FMT_INT8, 16'd0);
		send_request(OP_SAMPLE, 32'h1234_5680, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h0000_007F, 1'b1, 20'd1);
		send_request(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1, 20'd0);
		send_request(OP_SAMPLE, 32'h0000_0001, 1'b1, 20'd1000);
	endtask

	task automatic test_int32_format();
		set_config(FMT_INT32, 16'd1);
		send_request(OP_SAMPLE, 32'h8000_0000, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0, DUR_MAX);
		send_request(OP_SAMPLE, 32'h0000_0000, 1'b1, 20'd0);
	endtask

	// Format code 3 behaves as int32; op code 3 is dropped with no result
	task automatic test_unused_codes();
		set_config(FMT_UNUSED, 16'd0);
		send_request(OP_NONE, 32'h8000_0000, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h8000_0000, 1'b1, 20'd5);
		send_request(OP_SAMPLE, 32'h0001_0000, 1'b1, 20'd7);
	endtask

	// Both clears ignore their data and frame end; only the full clear zeroes the totals
	task automatic test_clear_ops();
		send_request(OP_SAMPLE, 32'h4000_0000, 1'b0, 20'd0);
		send_request(OP_CLR_LEVEL, $urandom, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h0000_0100, 1'b1, 20'd3);
		send_request(OP_CLR_ALL, $urandom, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h0000_0000, 1'b1, 20'd2);
	endtask

	// Largest period: the level stays put while the peak keeps building
	task automatic test_long_period();
		set_config(FMT_INT16, 16'hFFFF);
		send_request(OP_SAMPLE, 32'h0000_8000, 1'b1, 20'd9);
		send_request(OP_SAMPLE, 32'h0000_1234, 1'b0, 20'd0);
		send_request(OP_SAMPLE, 32'h0000_7FFF, 1'b1, DUR_MAX);
	endtask

	// Result side held off for a long spell while frame ends keep coming: the queue fills
	// and the request side must stall without losing or reordering anything
	task automatic test_backpressure();
		set_config(FMT_INT16, 16'd0);
		set_idling(0, 0);
		hold_reqs++;
		for (int i = 0; i < 24; i++)
			send_request(OP_SAMPLE, $urandom, 1'b1, 20'($urandom));
	endtask

	// Random frames in three idling modes, two register settings per mode
	task automatic test_random_traffic();
		int          send_pct [3]    = '{36, 60, 0};
		int          recv_pct [3]    = '{60, 36, 0};
		logic [1:0]  fmt_plan [6]    = '{FMT_INT8, FMT_INT16, FMT_INT32,
		                                 FMT_UNUSED, FMT_INT16, FMT_INT8};
		logic [15:0] period_plan [6] = '{16'd0, 16'd2, 16'd1, 16'd5, 16'hFFFF, 16'd0};
		int          sent;
		int          n;
		period_plan[5] = 16'($urandom_range(3, 7));
		for (int m = 0; m < 3; m++) begin
			for (int k = 0; k < 2; k++) begin
				set_config(fmt_plan[2*m+k], period_plan[2*m+k]);
				set_idling(send_pct[m], recv_pct[m]);
				sent = 0;
				while (sent < RANDOM_REQS / 6) begin
					send_random_frame(n);
					sent += n;
				end
			end
		end
	endtask

	// Full-scale frames of maximum length: the widest square and duration product the
	// energy path sees, building a large total. Neither total gets near its ceiling here.
	task automatic test_full_scale_frames();
		set_idling(0, 0);
		set_config(FMT_INT32, 16'd0);
		send_request(OP_CLR_ALL, $urandom, 1'b1, DUR_MAX);
		repeat (FULL_FRAMES)
			send_request(OP_SAMPLE, 32'h8000_0000, 1'b1, DUR_MAX);
		send_request(OP_SAMPLE, 32'h0000_0001, 1'b1, 20'd1);
	endtask

	// Result side: random tready, or a counted hold when the test asks for one
	always @(posedge clk) begin
		if (hold_reqs != holds_started) begin
			holds_started = hold_reqs;
			hold_left     = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Every result taken must match the oldest predicted one, field by field
	always @(posedge clk) begin : check_results
		meter_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_results_due.size() == 0) begin
				note_mismatch("result with nothing due", m_tdata[63:0], '0);
			end else begin
				want = frame_results_due.pop_front();
				if (m_tdata[31:0] !== want.level)
					note_mismatch("level", {32'd0, m_tdata[31:0]}, {32'd0, want.level});
				if (m_tdata[63:32] !== want.peak)
					note_mismatch("peak", {32'd0, m_tdata[63:32]}, {32'd0, want.peak});
				if (m_tdata[127:64] !== want.energy)
					note_mismatch("energy total", m_tdata[127:64], want.energy);
				if (m_tdata[175:128] !== want.time_us)
					note_mismatch("total_time_us", {16'd0, m_tdata[175:128]},
						{16'd0, want.time_us});
				results_seen++;
			end
		end
	end

	// Watchdog: too long with no request, result or register access moving ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: nothing moved for %0d cycles, %0d results still due",
				STALL_LIMIT, frame_results_due.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(36, 60);
		test_reset_defaults();
		test_int8_format();
		test_int32_format();
		test_unused_codes();
		test_clear_ops();
		test_long_period();
		test_backpressure();
		test_random_traffic();
		test_full_scale_frames();
		wait_for_quiet();
		$display("Covered %0d requests and %0d frame results: all sample widths, periods 0 to 65535,",
			reqs_accepted, results_seen);
		$display("both clears, ignored ops, a long result stall and full-scale energy frames.");
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: audio_peak_level_meter_top.f
hdl/apm_pkg.sv
hdl/apm_front.sv
hdl/apm_fifo.sv
hdl/apm_back.sv
hdl/audio_peak_level_meter_top.sv
dv/tb_audio_peak_level_meter_top.sv
